>>> rtl/core/spcr_pkg.sv
// Package for the shared port collision resolver.
// Holds slot count, opcode, collision method and register index codes.
// No dependencies; imported by shared_port_collision_resolver.
package spcr_pkg;

    // Number of usable slots, eight. The port always carries eight slot lanes.
    localparam int MAX_DEVICES = 8;
    localparam int NUM_LANES = 8;
    localparam int SLOT_W = 3;
    localparam int CAPS_W = 5;
    localparam int ORDER_W = 8;

    localparam logic [7:0] ALL_ONES = 8'hFF;
    localparam logic [ORDER_W-1:0] ORDER_FULL = 8'hFF;

    typedef enum logic [1:0] {
        OP_READ = 2'd0,
        OP_ATTACH = 2'd1,
        OP_DETACH = 2'd2
    } opcode_t;

    // Collision method codes; the value 3 behaves as detach last.
    localparam logic [1:0] METH_DETACH_ALL = 2'd0;
    localparam logic [1:0] METH_DETACH_LAST = 2'd1;
    localparam logic [1:0] METH_WIRED_AND = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_METHOD = 1'b0;
    localparam logic CFG_CAPS = 1'b1;

endpackage

>>> rtl/core/shared_port_collision_resolver.sv
// Shared port collision resolver: attach, detach and wired-AND read resolution
// for up to eight devices on one 8-bit port. Depends on spcr_pkg.
//
// Channel   Signals                           Flow control
// req       req_valid, req_stall, 8 fields    valid / stall, stall from this block
// rsp       rsp_valid, rsp_stall, 5 fields    valid / stall, stall from the sink
// cfg       cfg_valid, cfg_ready, index, data valid / ready, ready always high
//
// One beat per cycle sustained while the response is not stalled. A request beat is
// registered, resolved by parallel slot logic (pairwise order compares across the eight
// slots), and its result is loaded into the response register once that register is free.
// The slot state updates in the same cycle the result is captured.
// Reset clears the attach flags, the order counter and the configuration to
// method 0 and all capability bits set. A stalled response holds both stages.
module shared_port_collision_resolver
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    opcode,
    input  logic [spcr_pkg::SLOT_W-1:0]   device_slot,
    input  logic [spcr_pkg::CAPS_W-1:0]   device_needs,
    input  logic [7:0]                    access_mask,
    input  logic [7:0]                    fallback_value,
    input  logic [7:0]                    responders,
    input  logic [63:0]                   drive_masks,
    input  logic [63:0]                   drive_values,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [7:0]                    read_data,
    output logic                          any_driver,
    output logic                          collision,
    output logic [7:0]                    detached_slots,
    output logic                          attach_ok,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [spcr_pkg::CAPS_W-1:0]   cfg_data
);
    import spcr_pkg::*;

    // Configuration
    logic [1:0]          method_reg;
    logic [CAPS_W-1:0]   caps_reg;

    // Slot state
    logic [NUM_LANES-1:0]  attached_reg, attached_next;
    logic [ORDER_W-1:0]    order_reg [NUM_LANES];
    logic [ORDER_W-1:0]    order_next [NUM_LANES];
    logic [ORDER_W-1:0]    next_order_reg, next_order_next;

    // Request stage
    logic                s1_valid_reg;
    logic [1:0]          s1_op_reg;
    logic [SLOT_W-1:0]   s1_slot_reg;
    logic [CAPS_W-1:0]   s1_needs_reg;
    logic [7:0]          s1_amask_reg;
    logic [7:0]          s1_fallback_reg;
    logic [7:0]          s1_resp_reg;
    logic [63:0]         s1_dmasks_reg;
    logic [63:0]         s1_dvals_reg;

    // Response stage
    logic                rsp_valid_reg;
    logic [7:0]          data_reg, data_next;
    logic                any_reg, any_next;
    logic                coll_reg, coll_next;
    logic [7:0]          detached_reg, detached_next;
    logic                ok_reg, ok_next;

    logic                out_free;
    logic                proc_fire;

    // Read resolution
    logic [7:0]          rm [NUM_LANES];
    logic [7:0]          rv [NUM_LANES];
    logic [NUM_LANES-1:0] drv;
    logic [7:0]          wired;
    logic                multi;
    logic [NUM_LANES-1:0] first_vec;
    logic [7:0]          rv_first;
    logic [NUM_LANES-1:0] differ;
    logic [NUM_LANES-1:0] involved;
    logic [NUM_LANES-1:0] top_vec;
    logic [ORDER_W-1:0]  order_top;
    logic                coll_hit;
    logic                slot_in_range;
    logic                give_back_slot;
    logic                give_back_top;
    logic [ORDER_W-1:0]  newest_order;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign proc_fire = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign cfg_ready = 1'b1;

    assign rsp_valid = rsp_valid_reg;
    assign read_data = data_reg;
    assign any_driver = any_reg;
    assign collision = coll_reg;
    assign detached_slots = detached_reg;
    assign attach_ok = ok_reg;

    assign slot_in_range = {1'b0, s1_slot_reg} < (SLOT_W + 1)'(MAX_DEVICES);
    assign newest_order = next_order_reg - 8'd1;

    // Per-slot drive masks and values, plus the wired AND of all drivers.
    always_comb
    begin
        wired = ALL_ONES;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            rm[i] = s1_dmasks_reg[8*i +: 8] & s1_amask_reg;
            rv[i] = s1_dvals_reg[8*i +: 8] | ~rm[i];
            drv[i] = (i < MAX_DEVICES) && attached_reg[i] && s1_resp_reg[i]
                     && (rm[i] != 8'd0);
            if (drv[i])
            begin
                wired = wired & rv[i];
            end
        end
    end

    assign multi = (drv & (drv - 8'd1)) != 8'd0;

    // The lowest-order driver wins every pairwise compare; ties go to the lower slot.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            first_vec[i] = drv[i];
            for (int j = 0; j < NUM_LANES; j++)
            begin
                if (j != i && drv[j])
                begin
                    if (!((order_reg[i] < order_reg[j])
                          || ((order_reg[i] == order_reg[j]) && (i < j))))
                    begin
                        first_vec[i] = 1'b0;
                    end
                end
            end
        end
    end

    // The first driver's value is complete before any slot is compared against it.
    always_comb
    begin
        rv_first = 8'd0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            if (first_vec[i])
            begin
                rv_first = rv_first | rv[i];
            end
        end
        for (int i = 0; i < NUM_LANES; i++)
        begin
            differ[i] = drv[i] && (rv[i] != rv_first);
        end
    end

    assign involved = differ | first_vec;

    // Attached orders are distinct, so the highest-order involved slot is unique.
    always_comb
    begin
        order_top = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            top_vec[i] = involved[i];
            for (int j = 0; j < NUM_LANES; j++)
            begin
                if (j != i && involved[j])
                begin
                    if (!((order_reg[i] > order_reg[j])
                          || ((order_reg[i] == order_reg[j]) && (i < j))))
                    begin
                        top_vec[i] = 1'b0;
                    end
                end
            end
            if (top_vec[i])
            begin
                order_top = order_top | order_reg[i];
            end
        end
    end

    assign coll_hit = multi && (method_reg != METH_WIRED_AND) && (differ != 8'd0);
    assign give_back_top = (next_order_reg != 8'd0) && (order_top == newest_order);
    assign give_back_slot = (next_order_reg != 8'd0)
                            && (order_reg[s1_slot_reg] == newest_order);

    always_comb
    begin
        attached_next = attached_reg;
        order_next = order_reg;
        next_order_next = next_order_reg;
        data_next = 8'd0;
        any_next = 1'b0;
        coll_next = 1'b0;
        detached_next = 8'd0;
        ok_next = 1'b0;
        unique case (s1_op_reg)
            OP_ATTACH:
            begin
                if (slot_in_range && !attached_reg[s1_slot_reg]
                    && ((s1_needs_reg & ~caps_reg) == '0)
                    && (next_order_reg != ORDER_FULL))
                begin
                    attached_next[s1_slot_reg] = 1'b1;
                    order_next[s1_slot_reg] = next_order_reg;
                    next_order_next = next_order_reg + 8'd1;
                    ok_next = 1'b1;
                end
            end
            OP_DETACH:
            begin
                if (slot_in_range && attached_reg[s1_slot_reg])
                begin
                    attached_next[s1_slot_reg] = 1'b0;
                    if (give_back_slot)
                    begin
                        next_order_next = newest_order;
                    end
                    detached_next = 8'd1 << s1_slot_reg;
                end
            end
            OP_READ:
            begin
                if (s1_amask_reg == 8'd0)
                begin
                    data_next = ALL_ONES;
                end
                else if (drv == 8'd0)
                begin
                    data_next = s1_fallback_reg;
                end
                else
                begin
                    any_next = 1'b1;
                    data_next = wired;
                    if (multi && (method_reg != METH_WIRED_AND))
                    begin
                        data_next = rv_first;
                    end
                    if (coll_hit)
                    begin
                        coll_next = 1'b1;
                        if (give_back_top)
                        begin
                            next_order_next = newest_order;
                        end
                        if (method_reg == METH_DETACH_ALL)
                        begin
                            attached_next = attached_reg & ~involved;
                            detached_next = involved;
                            data_next = ALL_ONES;
                        end
                        else
                        begin
                            attached_next = attached_reg & ~top_vec;
                            detached_next = top_vec;
                        end
                    end
                end
            end
            default:
            begin
                data_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= METH_DETACH_ALL;
            caps_reg <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_METHOD)
            begin
                method_reg <= cfg_data[1:0];
            end
            else
            begin
                caps_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attached_reg <= '0;
            next_order_reg <= '0;
            s1_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
            begin
                s1_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
            if (proc_fire)
            begin
                attached_reg <= attached_next;
                next_order_reg <= next_order_next;
            end
        end
    end

    // Payload registers; the order store is only read for attached slots.
    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            s1_op_reg <= opcode;
            s1_slot_reg <= device_slot;
            s1_needs_reg <= device_needs;
            s1_amask_reg <= access_mask;
            s1_fallback_reg <= fallback_value;
            s1_resp_reg <= responders;
            s1_dmasks_reg <= drive_masks;
            s1_dvals_reg <= drive_values;
        end
        if (proc_fire)
        begin
            order_reg <= order_next;
            data_reg <= data_next;
            any_reg <= any_next;
            coll_reg <= coll_next;
            detached_reg <= detached_next;
            ok_reg <= ok_next;
        end
    end

    // Only slots that were attached can be reported as detached.
    a_detach_attached: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> ((detached_slots & $past(attached_reg)) == detached_slots))
        else $error("detached a slot that was not attached");

    // A collision can only be reported when some device drove the port.
    a_coll_driver: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && collision) |-> any_driver)
        else $error("collision without a driver");

    // An accepted attach grows the order counter and detaches nothing.
    a_attach_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && ok_next) |=> ((detached_slots == 8'd0) && !collision
                                   && (next_order_reg == $past(next_order_reg) + 8'd1)))
        else $error("attach result inconsistent");

endmodule
